// ===== rtl/dpf_pkg.sv =====
// Shared types and constants for the packet queue with duplicate rejection and windowed count.
package dpf_pkg;

    localparam int OP_W      = 2;
    localparam int CFG_W     = 7;
    localparam int WIN_W     = 32;
    localparam int CNT_W     = 7;

    localparam logic [CFG_W-1:0] CAP_RESET = 7'd64;

    typedef enum logic [OP_W-1:0] {
        OP_ADD = 2'd0,
        OP_FWD = 2'd1,
        OP_CNT = 2'd2,
        OP_NOP = 2'd3
    } t_opcode;

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SCAN   = 3'b010,
        S_FINISH = 3'b100
    } t_state;

endpackage

// ===== rtl/dpf_ram.sv =====
// Simple dual-port synchronous RAM with one write port and one registered read port.
module dpf_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/dedup_packet_fifo_with_window_count.sv =====
// Packet queue top level: sequencer, queue pointers, configuration register and result register.
//
// The block holds up to QUEUE_DEPTH packets in a single synchronous RAM organised as a circular
// queue. Each transaction on the input channel carries one operation: add, forward, count or
// no operation, and produces exactly one transaction on the output channel. Add and count scan
// every queued packet through the one RAM read port, one entry per cycle; a forward reads
// only the head entry, if the queue holds one, and no operation reads nothing. The result
// appears in the cycle in which the block is ready for the next input transaction. A
// finished result waits in the output register while the next item is accepted and
// scanned; that item completes only once the earlier result has been taken. The capacity
// register is accepted only while the block is idle; values of zero act as one and values
// above QUEUE_DEPTH act as QUEUE_DEPTH.
module dedup_packet_fifo_with_window_count #(
    parameter int QUEUE_DEPTH = 64,
    parameter int ID_BITS     = 16,
    parameter int TIME_BITS   = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,

    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [dpf_pkg::CFG_W-1:0]       i_cfg_data,

    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [dpf_pkg::OP_W-1:0]        i_opcode,
    input  logic [ID_BITS-1:0]              i_src_id,
    input  logic [ID_BITS-1:0]              i_dst_id,
    input  logic [TIME_BITS-1:0]            i_stamp,
    input  logic [dpf_pkg::WIN_W-1:0]       i_window_start,
    input  logic [dpf_pkg::WIN_W-1:0]       i_window_end,

    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic                            o_added,
    output logic                            o_packet_valid,
    output logic [ID_BITS-1:0]              o_out_src,
    output logic [ID_BITS-1:0]              o_out_dst,
    output logic [TIME_BITS-1:0]            o_out_stamp,
    output logic [dpf_pkg::CNT_W-1:0]       o_match_count
);

    import dpf_pkg::*;

    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W = OCC_W + 1;
    localparam int CMP_W = (OCC_W > CFG_W) ? OCC_W : CFG_W;
    localparam int PKT_W = 2 * ID_BITS + TIME_BITS;

    t_state                 r_state;
    t_state                 n_state;
    t_opcode                r_op;
    logic [ID_BITS-1:0]     r_src;
    logic [ID_BITS-1:0]     r_dst;
    logic [TIME_BITS-1:0]   r_stamp;
    logic [WIN_W-1:0]       r_wlo;
    logic [WIN_W-1:0]       r_whi;
    logic [CFG_W-1:0]       r_cap;
    logic [IDX_W-1:0]       r_head;
    logic [OCC_W-1:0]       r_occ;
    logic [OCC_W-1:0]       r_issue;
    logic [OCC_W-1:0]       r_scan_len;
    logic                   r_pend;
    logic                   r_dup;
    logic [CNT_W-1:0]       r_count;
    logic [PKT_W-1:0]       r_fwd;
    logic                   r_out_valid;

    logic                   in_fire;
    logic                   rd_en;
    logic [IDX_W-1:0]       rd_addr;
    logic [PKT_W-1:0]       rd_data;
    logic                   wr_en;
    logic [IDX_W-1:0]       wr_addr;
    logic                   scan_done;
    logic                   fin_go;
    logic                   evict;
    logic [CMP_W-1:0]       eff_lim;
    logic [ID_BITS-1:0]     rd_src;
    logic [ID_BITS-1:0]     rd_dst;
    logic [TIME_BITS-1:0]   rd_stamp;
    logic                   dup_hit;
    logic                   cnt_hit;

    function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] head,
                                                 input logic [OCC_W-1:0] off);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(head) + SUM_W'(off);
        if (sum >= SUM_W'(QUEUE_DEPTH)) begin
            sum = sum - SUM_W'(QUEUE_DEPTH);
        end
        return sum[IDX_W-1:0];
    endfunction

    assign o_cfg_ready = (r_state == S_IDLE);
    assign o_in_ready  = (r_state == S_IDLE);
    assign in_fire     = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;

    assign rd_en     = (r_state == S_SCAN) && (r_issue != r_scan_len);
    assign rd_addr   = slot_of(r_head, r_issue);
    assign scan_done = (r_state == S_SCAN) && !rd_en && !r_pend;
    assign fin_go    = (r_state == S_FINISH) && (!r_out_valid || i_out_ready);

    assign rd_src   = rd_data[PKT_W-1 -: ID_BITS];
    assign rd_dst   = rd_data[TIME_BITS +: ID_BITS];
    assign rd_stamp = rd_data[TIME_BITS-1:0];
    assign dup_hit  = (rd_src == r_src) && (rd_dst == r_dst) && (rd_stamp == r_stamp);
    assign cnt_hit  = (rd_dst == r_dst) && (WIN_W'(rd_stamp) >= r_wlo)
                      && (WIN_W'(rd_stamp) <= r_whi);

    always_comb begin
        eff_lim = CMP_W'(r_cap);
        if (r_cap == '0) begin
            eff_lim = CMP_W'(1);
        end
        if (eff_lim > CMP_W'(QUEUE_DEPTH)) begin
            eff_lim = CMP_W'(QUEUE_DEPTH);
        end
    end

    assign evict   = (CMP_W'(r_occ) >= eff_lim) && (r_occ != '0);
    assign wr_en   = fin_go && (r_op == OP_ADD) && !r_dup;
    assign wr_addr = slot_of(r_head, r_occ);

    dpf_ram #(
        .DEPTH (QUEUE_DEPTH),
        .WIDTH (PKT_W)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data ({r_src, r_dst, r_stamp}),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (scan_done) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (fin_go) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cap       <= CAP_RESET;
            r_head      <= '0;
            r_occ       <= '0;
            r_issue     <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pend  <= rd_en;
            if (i_cfg_valid && o_cfg_ready) begin
                r_cap <= i_cfg_data;
            end
            if (in_fire) begin
                r_issue <= '0;
            end else if (rd_en) begin
                r_issue <= r_issue + OCC_W'(1);
            end
            if (fin_go) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (fin_go) begin
                unique case (r_op)
                    OP_ADD: begin
                        if (!r_dup) begin
                            if (evict) begin
                                r_head <= slot_of(r_head, OCC_W'(1));
                            end else begin
                                r_occ <= r_occ + OCC_W'(1);
                            end
                        end
                    end
                    OP_FWD: begin
                        if (r_occ != '0) begin
                            r_head <= slot_of(r_head, OCC_W'(1));
                            r_occ  <= r_occ - OCC_W'(1);
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_op    <= t_opcode'(i_opcode);
            r_src   <= i_src_id;
            r_dst   <= i_dst_id;
            r_stamp <= i_stamp;
            r_wlo   <= i_window_start;
            r_whi   <= i_window_end;
            r_dup   <= 1'b0;
            r_count <= '0;
            r_fwd   <= '0;
            unique case (t_opcode'(i_opcode))
                OP_ADD, OP_CNT: r_scan_len <= r_occ;
                OP_FWD:         r_scan_len <= OCC_W'(r_occ != '0);
                default:        r_scan_len <= '0;
            endcase
        end else if (r_pend) begin
            if (r_op == OP_ADD && dup_hit) begin
                r_dup <= 1'b1;
            end
            if (r_op == OP_CNT && cnt_hit) begin
                r_count <= r_count + CNT_W'(1);
            end
            if (r_op == OP_FWD) begin
                r_fwd <= rd_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fin_go) begin
            o_added        <= 1'b0;
            o_packet_valid <= 1'b0;
            o_out_src      <= '0;
            o_out_dst      <= '0;
            o_out_stamp    <= '0;
            o_match_count  <= '0;
            unique case (r_op)
                OP_ADD: o_added <= !r_dup;
                OP_FWD: begin
                    o_packet_valid <= (r_occ != '0);
                    o_out_src      <= r_fwd[PKT_W-1 -: ID_BITS];
                    o_out_dst      <= r_fwd[TIME_BITS +: ID_BITS];
                    o_out_stamp    <= r_fwd[TIME_BITS-1:0];
                end
                OP_CNT: o_match_count <= r_count;
                default: o_added <= 1'b0;
            endcase
        end
    end

    a_no_rw_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(rd_en && wr_en))
        else $error("RAM read and write issued in the same cycle");

    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= OCC_W'(QUEUE_DEPTH))
        else $error("Occupancy exceeds queue depth");

    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_issue <= r_scan_len))
        else $error("Scan issued beyond the queued entries");

    a_add_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |=> (r_occ != '0))
        else $error("Queue empty after an accepted add");

    a_fwd_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fin_go && r_op == OP_FWD && r_occ == '0) |=> !o_packet_valid)
        else $error("Forward on an empty queue returned a packet");

endmodule
